// ===== rtl/pfrm_pkg.sv =====
// Shared constants and control types of the pulse flow rate meter.
package pfrm_pkg;

   // Event codes carried in the request beat
   localparam logic [1:0] FUNC_PULSE = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_PPL_X16  = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   // Configuration reset values
   localparam logic [15:0] PPL_X16_RESET = 16'd7200;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

   // 16 * 60000 ms/min * 1000 mL/L, and 16 * 1000 mL/L
   localparam logic [29:0] ML_PER_MIN_X16 = 30'd960000000;
   localparam logic [13:0] ML_PER_L_X16   = 14'd16000;

   // Divider geometry: 64-bit dividend, 48-bit divisor, 33 quotient bits
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int QUO_BITS  = 33;
   localparam int DIV_CNT_W = 6;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic rate_start;
      logic rate_load;
      logic vol_mul;
      logic vol_start;
      logic vol_load;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_rate;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/pulse_flow_rate_meter_top.sv =====
// Top level of the pulse flow rate meter: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_func, req_now_ms
//   rsp      out        rsp_valid / rsp_ready  rsp_flow_ml_per_min, rsp_pulse_total,
//                                              rsp_volume_ml
//   csr      in         csr_write_en           csr_index, csr_write_data
//
// One beat at a time. A pulse, clear or plain tick runs one division, a tick that
// computes a rate two: each division runs a restoring divider at one quotient bit
// a cycle (33 steps plus load and range check).
// Synchronous active-high reset restores the configuration defaults and zeroes
// the meter state. A waiting result beat does not block the next request; the
// controller only stalls when a new result is ready and the old one is untaken.
module pulse_flow_rate_meter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_flow_ml_per_min,
   output logic [31:0] rsp_pulse_total,
   output logic [31:0] rsp_volume_ml,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   pfrm_pkg::cmd_type cmd;
   pfrm_pkg::sts_type sts;

   pfrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pfrm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_now_ms          (req_now_ms),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_flow_ml_per_min (rsp_flow_ml_per_min),
      .rsp_pulse_total     (rsp_pulse_total),
      .rsp_volume_ml       (rsp_volume_ml)
   );

endmodule

// ===== rtl/pfrm_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
module pfrm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pfrm_pkg::DIV_NUM_W-1:0]      num,
   input  logic [pfrm_pkg::DIV_DEN_W-1:0]      den,
   output logic                                done,
   output logic [31:0]                         quot
);

   localparam int LOW_W = pfrm_pkg::QUO_BITS;
   localparam int HI_W  = pfrm_pkg::DIV_NUM_W - LOW_W;

   logic                                 busy_ff, busy_in;
   logic                                 check_ff, check_in;
   logic                                 done_ff, done_in;
   logic [pfrm_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pfrm_pkg::DIV_DEN_W-1:0]       den_ff, den_in;
   logic [pfrm_pkg::DIV_DEN_W-1:0]       rem_ff, rem_in;
   logic [LOW_W-1:0]                     low_ff, low_in;
   logic [LOW_W-1:0]                     quo_ff, quo_in;
   logic [31:0]                          quot_ff, quot_in;

   logic [pfrm_pkg::DIV_DEN_W:0]         trial;
   logic [pfrm_pkg::DIV_DEN_W:0]         trial_diff;
   logic                                 ge;

   // Trial subtract of the shifted remainder
   assign trial      = {rem_ff, low_ff[LOW_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign ge         = (trial >= {1'b0, den_ff});

   // Sequence load, range check and the bit steps
   always_comb begin
      busy_in  = busy_ff;
      check_in = check_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         check_in = 1'b1;
         den_in   = den;
         rem_in   = {{(pfrm_pkg::DIV_DEN_W-HI_W){1'b0}}, num[pfrm_pkg::DIV_NUM_W-1:LOW_W]};
         low_in   = num[LOW_W-1:0];
         quo_in   = '0;
      end else if (busy_ff && check_ff) begin
         // quotient of 2^33 or more saturates at once
         if (rem_ff >= den_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = '1;
         end else begin
            check_in = 1'b0;
            cnt_in   = pfrm_pkg::DIV_CNT_W'(LOW_W);
         end
      end else if (busy_ff) begin
         rem_in = ge ? trial_diff[pfrm_pkg::DIV_DEN_W-1:0] : trial[pfrm_pkg::DIV_DEN_W-1:0];
         low_in = {low_ff[LOW_W-2:0], 1'b0};
         quo_in = {quo_ff[LOW_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pfrm_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = quo_ff[LOW_W-2] ? '1 : {quo_ff[30:0], ge};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         check_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         check_ff <= check_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/pfrm_dp.sv =====
// Datapath: meter state, configuration, products, divider and result register.
module pfrm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  pfrm_pkg::cmd_type    cmd,
   output pfrm_pkg::sts_type    sts,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_now_ms,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [15:0]          csr_write_data,
   output logic [31:0]          rsp_flow_ml_per_min,
   output logic [31:0]          rsp_pulse_total,
   output logic [31:0]          rsp_volume_ml
);

   logic [15:0] ppl_ff, ppl_in;
   logic [15:0] timeout_ff, timeout_in;

   logic [1:0]  func_ff, func_in;
   logic [31:0] now_ff, now_in;

   logic [31:0] total_ff, total_in;
   logic        present_ff, present_in;
   logic [31:0] prev_count_ff, prev_count_in;
   logic [31:0] prev_time_ff, prev_time_in;
   logic [31:0] last_count_ff, last_count_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] vol_ff, vol_in;

   logic [pfrm_pkg::DIV_NUM_W-1:0] prod_num_ff, prod_num_in;
   logic [pfrm_pkg::DIV_DEN_W-1:0] prod_den_ff, prod_den_in;

   logic [31:0] out_rate_ff, out_total_ff, out_vol_ff;

   logic [15:0] ppl_eff;
   logic [31:0] total_inc;
   logic [31:0] idle_ms;
   logic [31:0] count_diff;
   logic [31:0] time_diff;
   logic [61:0] rate_num;
   logic [47:0] rate_den;
   logic [45:0] vol_num;
   logic        div_start;
   logic        div_done;
   logic [31:0] div_quot;

   assign ppl_eff    = (ppl_ff == 16'd0) ? 16'd1 : ppl_ff;
   assign total_inc  = total_ff + 32'd1;
   assign idle_ms    = now_ff - last_time_ff;
   assign count_diff = last_count_ff - prev_count_ff;
   assign time_diff  = last_time_ff - prev_time_ff;
   assign rate_num   = count_diff * pfrm_pkg::ML_PER_MIN_X16;
   assign rate_den   = ppl_eff * time_diff;
   assign vol_num    = total_ff * pfrm_pkg::ML_PER_L_X16;

   // A tick with two samples at different times needs a division
   assign sts.need_rate = (func_ff == pfrm_pkg::FUNC_TICK) && present_ff &&
                          (prev_time_ff != last_time_ff);
   assign sts.div_done  = div_done;

   // Take configuration writes
   always_comb begin
      ppl_in     = ppl_ff;
      timeout_in = timeout_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pfrm_pkg::CSR_PPL_X16: ppl_in     = csr_write_data;
            pfrm_pkg::CSR_TIMEOUT: timeout_in = csr_write_data;
            default:               ppl_in     = ppl_ff;
         endcase
      end
   end

   // Hold the accepted beat
   assign func_in = cmd.capture ? req_func : func_ff;
   assign now_in  = cmd.capture ? req_now_ms : now_ff;

   // Apply the event and the division results
   always_comb begin
      total_in      = total_ff;
      present_in    = present_ff;
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      last_count_in = last_count_ff;
      last_time_in  = last_time_ff;
      rate_in       = rate_ff;
      vol_in        = vol_ff;
      prod_num_in   = prod_num_ff;
      prod_den_in   = prod_den_ff;
      if (cmd.eval) begin
         unique case (func_ff)
            pfrm_pkg::FUNC_PULSE: begin
               total_in      = total_inc;
               last_count_in = total_inc;
               last_time_in  = now_ff;
               if (!present_ff) begin
                  prev_count_in = total_inc;
                  prev_time_in  = now_ff;
                  present_in    = 1'b1;
               end
            end
            pfrm_pkg::FUNC_TICK: begin
               if (!present_ff) begin
                  rate_in = '0;
               end else if (prev_time_ff == last_time_ff) begin
                  // drop stale samples after the idle timeout
                  if (idle_ms > {16'd0, timeout_ff}) begin
                     present_in    = 1'b0;
                     prev_count_in = '0;
                     prev_time_in  = '0;
                     last_count_in = '0;
                     last_time_in  = '0;
                     rate_in       = '0;
                  end
               end else begin
                  prod_num_in   = {2'b00, rate_num};
                  prod_den_in   = rate_den;
                  prev_count_in = last_count_ff;
                  prev_time_in  = last_time_ff;
               end
            end
            pfrm_pkg::FUNC_CLEAR: begin
               total_in      = '0;
               present_in    = 1'b0;
               prev_count_in = '0;
               prev_time_in  = '0;
               last_count_in = '0;
               last_time_in  = '0;
               rate_in       = '0;
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
      if (cmd.vol_mul) begin
         prod_num_in = {18'd0, vol_num};
         prod_den_in = {32'd0, ppl_eff};
      end
      if (cmd.rate_load) begin
         rate_in = div_quot;
      end
      if (cmd.vol_load) begin
         vol_in = div_quot;
      end
   end

   assign div_start = cmd.rate_start | cmd.vol_start;

   pfrm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_num_ff),
      .den   (prod_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Configuration and meter state
   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff        <= pfrm_pkg::PPL_X16_RESET;
         timeout_ff    <= pfrm_pkg::TIMEOUT_RESET;
         total_ff      <= '0;
         present_ff    <= 1'b0;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         last_count_ff <= '0;
         last_time_ff  <= '0;
         rate_ff       <= '0;
      end else begin
         ppl_ff        <= ppl_in;
         timeout_ff    <= timeout_in;
         total_ff      <= total_in;
         present_ff    <= present_in;
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
         last_count_ff <= last_count_in;
         last_time_ff  <= last_time_in;
         rate_ff       <= rate_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      now_ff      <= now_in;
      vol_ff      <= vol_in;
      prod_num_ff <= prod_num_in;
      prod_den_ff <= prod_den_in;
      if (cmd.out_load) begin
         out_rate_ff  <= rate_ff;
         out_total_ff <= total_ff;
         out_vol_ff   <= vol_ff;
      end
   end

   assign rsp_flow_ml_per_min = out_rate_ff;
   assign rsp_pulse_total     = out_total_ff;
   assign rsp_volume_ml       = out_vol_ff;

endmodule

// ===== rtl/pfrm_ctrl.sv =====
// Controller: sequences one event through update, divisions and the result beat.
module pfrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfrm_pkg::cmd_type    cmd,
   input  pfrm_pkg::sts_type    sts
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_EVAL      = 9'b000000010,
      ST_RATE_GO   = 9'b000000100,
      ST_RATE_WAIT = 9'b000001000,
      ST_VOL_MUL   = 9'b000010000,
      ST_VOL_GO    = 9'b000100000,
      ST_VOL_WAIT  = 9'b001000000,
      ST_OUT       = 9'b010000000,
      ST_SPARE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.need_rate ? ST_RATE_GO : ST_VOL_MUL;
         end
         ST_RATE_GO: begin
            cmd.rate_start = 1'b1;
            state_in       = ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (sts.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = ST_VOL_MUL;
            end
         end
         ST_VOL_MUL: begin
            cmd.vol_mul = 1'b1;
            state_in    = ST_VOL_GO;
         end
         ST_VOL_GO: begin
            cmd.vol_start = 1'b1;
            state_in      = ST_VOL_WAIT;
         end
         ST_VOL_WAIT: begin
            if (sts.div_done) begin
               cmd.vol_load = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
